// File: rtl/core/dfpp_pkg.sv
// ----------------------------------------------------------------------------
// dfpp_pkg
// Shared constants for the dollar-framed packet parser: byte codes, frame
// phases and end-of-frame status codes.
// ----------------------------------------------------------------------------
package dfpp_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int PHASE_W  = 3;

   // Framing bytes
   localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h24;
   localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0d;
   localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0a;
   localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd7;

   // Parser phases
   localparam logic [PHASE_W-1:0] PH_HUNT1   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HUNT2   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEN     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_REQID   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
   localparam logic [PHASE_W-1:0] PH_CHECK   = 3'd5;
   localparam logic [PHASE_W-1:0] PH_CR      = 3'd6;
   localparam logic [PHASE_W-1:0] PH_LF      = 3'd7;

   // End-of-frame status
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CSUM    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TRAILER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd3;

endpackage

// File: rtl/core/dollar_framed_packet_parser_core.sv
// ----------------------------------------------------------------------------
// dollar_framed_packet_parser_core
// Byte-stream parser for '$$'-framed packets: sync, length, request id,
// payload, XOR checksum, CR LF. Payload bytes pass out as they arrive; one
// end response per frame carries the request id and a status.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Ports                                  | Carries
//   --------+-----------+----------------------------------------+------------------
//   req     | in        | req_valid, req_ready, req_rx_byte      | one received byte
//   rsp     | out       | rsp_valid, rsp_ready, rsp_out_byte,    | payload byte or
//           |           | rsp_frame_end, rsp_request_id,         | end-of-frame
//           |           | rsp_frame_status                       | status
//
// Throughput is one request per cycle while the response side is not stalled; a
// request's response, if any, passes the input register, then the output register.
// The frame state machine updates in the cycle a byte leaves the input register.
// Reset is synchronous, active high, and returns the parser to sync hunting.
// A stalled response holds the output register; the input register still
// takes one more request, and req_ready drops only while both are full.
// ----------------------------------------------------------------------------
module dollar_framed_packet_parser_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dfpp_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dfpp_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_frame_end,
   output logic [dfpp_pkg::BYTE_W-1:0]   rsp_request_id,
   output logic [dfpp_pkg::STATUS_W-1:0] rsp_frame_status
);
   import dfpp_pkg::*;

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // frame state
   logic [PHASE_W-1:0] phase_ff,        phase_in;
   logic [BYTE_W-1:0]  payload_left_ff, payload_left_in;
   logic [BYTE_W-1:0]  running_xor_ff,  running_xor_in;
   logic [BYTE_W-1:0]  request_id_ff,   request_id_in;
   logic               checksum_ok_ff,  checksum_ok_in;

   // output register
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff,   rsp_byte_in;
   logic                rsp_end_ff,    rsp_end_in;
   logic [BYTE_W-1:0]   rsp_id_ff,     rsp_id_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic out_free;
   logic step;
   logic emit;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // frame state machine, one byte per step
   always_comb begin
      phase_in        = phase_ff;
      payload_left_in = payload_left_ff;
      running_xor_in  = running_xor_ff;
      request_id_in   = request_id_ff;
      checksum_ok_in  = checksum_ok_ff;
      emit            = 1'b0;
      rsp_byte_in     = '0;
      rsp_end_in      = 1'b0;
      rsp_id_in       = request_id_ff;
      rsp_status_in   = ST_OK;
      if (step) begin
         case (phase_ff)
            PH_HUNT1: begin
               if (in_byte_ff == SYNC_BYTE) phase_in = PH_HUNT2;
            end
            PH_HUNT2: begin
               phase_in = (in_byte_ff == SYNC_BYTE) ? PH_LEN : PH_HUNT1;
            end
            PH_LEN: begin
               if (in_byte_ff < MIN_LENGTH) begin
                  // short frame: no id read yet, report id zero
                  phase_in      = PH_HUNT1;
                  emit          = 1'b1;
                  rsp_end_in    = 1'b1;
                  rsp_id_in     = '0;
                  rsp_status_in = ST_SHORT;
               end else begin
                  payload_left_in = in_byte_ff - MIN_LENGTH;
                  phase_in        = PH_REQID;
               end
            end
            PH_REQID: begin
               request_id_in  = in_byte_ff;
               running_xor_in = '0;
               phase_in       = (payload_left_ff != '0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
               running_xor_in  = running_xor_ff ^ in_byte_ff;
               payload_left_in = payload_left_ff - 8'd1;
               if (payload_left_ff == 8'd1) phase_in = PH_CHECK;
               emit        = 1'b1;
               rsp_byte_in = in_byte_ff;
            end
            PH_CHECK: begin
               checksum_ok_in = (in_byte_ff == running_xor_ff);
               phase_in       = PH_CR;
            end
            PH_CR: begin
               if (in_byte_ff != CR_BYTE) begin
                  phase_in      = PH_HUNT1;
                  emit          = 1'b1;
                  rsp_end_in    = 1'b1;
                  rsp_status_in = ST_TRAILER;
               end else begin
                  phase_in = PH_LF;
               end
            end
            default: begin
               // LF: trailer check wins over checksum
               phase_in   = PH_HUNT1;
               emit       = 1'b1;
               rsp_end_in = 1'b1;
               if (in_byte_ff != LF_BYTE) rsp_status_in = ST_TRAILER;
               else rsp_status_in = checksum_ok_ff ? ST_OK : ST_CSUM;
            end
         endcase
      end
   end

   // output valid follows the step when the slot is free
   assign rsp_valid_in = out_free ? emit : rsp_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_HUNT1;
         payload_left_ff <= '0;
         running_xor_ff  <= '0;
         request_id_ff   <= '0;
         checksum_ok_ff  <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         rsp_valid_ff    <= rsp_valid_in;
         phase_ff        <= phase_in;
         payload_left_ff <= payload_left_in;
         running_xor_ff  <= running_xor_in;
         request_id_ff   <= request_id_in;
         checksum_ok_ff  <= checksum_ok_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_byte_ff <= req_rx_byte;
      if (out_free) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_frame_end    = rsp_end_ff;
   assign rsp_request_id   = rsp_id_ff;
   assign rsp_frame_status = rsp_status_ff;

endmodule

// File: rtl/core/dfpp_checker.sv
// ----------------------------------------------------------------------------
// dfpp_checker
// Port-level checks for the packet parser core, attached by bind.
// ----------------------------------------------------------------------------
module dfpp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dfpp_pkg::BYTE_W-1:0]   rsp_out_byte,
   input logic                          rsp_frame_end,
   input logic [dfpp_pkg::BYTE_W-1:0]   rsp_request_id,
   input logic [dfpp_pkg::STATUS_W-1:0] rsp_frame_status
);
   import dfpp_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_frame_end) && $stable(rsp_request_id)
         && $stable(rsp_frame_status))
      else $error("response changed while stalled");

   // payload responses carry ok status
   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> rsp_frame_status == ST_OK)
      else $error("payload response with nonzero status");

   // end responses carry a zero data byte
   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_out_byte == '0)
      else $error("end response with nonzero byte");

   // no request accepted and the output stays empty, so no new response follows
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) && !rsp_valid ##1 !rsp_valid |=> !rsp_valid)
      else $error("response without a request");

   // reset empties the output
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind dollar_framed_packet_parser_core dfpp_checker u_dfpp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_frame_end    (rsp_frame_end),
   .rsp_request_id   (rsp_request_id),
   .rsp_frame_status (rsp_frame_status)
);

// File: test/dollar_framed_packet_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dollar_framed_packet_parser_core_tb
// Drives framed byte streams into the parser through its request channel and
// checks every response against a cycle-free frame predictor. A directed
// opener covers sync loss, short length, empty payload, checksum mismatch and
// a bad trailer, followed by random frames, noise and broken sequences with
// bursty input and a stalling response side.
// ----------------------------------------------------------------------------

module dollar_framed_packet_parser_core_tb;
   import dfpp_pkg::*;

   typedef struct {
      logic [BYTE_W-1:0]   out_byte;
      logic                frame_end;
      logic [BYTE_W-1:0]   request_id;
      logic [STATUS_W-1:0] frame_status;
   } parser_rsp_type;

   // Frame predictor plus the queue of responses it still expects
   class frame_scoreboard;
      logic [PHASE_W-1:0] phase;
      logic [BYTE_W-1:0]  bytes_left;
      logic [BYTE_W-1:0]  payload_xor;
      logic [BYTE_W-1:0]  frame_id;
      logic               csum_match;

      parser_rsp_type expected_rsps[$];
      int fail_count;
      int checked_count;
      int payload_count;
      int end_count[4];

      function new();
         phase       = PH_HUNT1;
         bytes_left  = '0;
         payload_xor = '0;
         frame_id    = '0;
         csum_match  = 1'b0;
         fail_count  = 0;
         checked_count = 0;
         payload_count = 0;
         foreach (end_count[i]) end_count[i] = 0;
      endfunction

      // Advance the frame state by one accepted request byte
      function void take_rx_byte(logic [BYTE_W-1:0] b);
         parser_rsp_type r;
         bit             emit;
         emit = 1'b0;
         r.out_byte     = '0;
         r.frame_end    = 1'b1;
         r.request_id   = frame_id;
         r.frame_status = ST_OK;
         case (phase)
            PH_HUNT1: begin
               if (b == SYNC_BYTE) phase = PH_HUNT2;
            end
            PH_HUNT2: begin
               phase = (b == SYNC_BYTE) ? PH_LEN : PH_HUNT1;
            end
            PH_LEN: begin
               if (b < MIN_LENGTH) begin
                  // no id read yet, so the id field is zero
                  phase          = PH_HUNT1;
                  emit           = 1'b1;
                  r.request_id   = '0;
                  r.frame_status = ST_SHORT;
               end else begin
                  bytes_left = b - MIN_LENGTH;
                  phase      = PH_REQID;
               end
            end
            PH_REQID: begin
               frame_id    = b;
               payload_xor = '0;
               phase       = (bytes_left != 0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD: begin
               payload_xor  = payload_xor ^ b;
               bytes_left   = bytes_left - 8'd1;
               if (bytes_left == 0) phase = PH_CHECK;
               emit         = 1'b1;
               r.out_byte   = b;
               r.frame_end  = 1'b0;
               r.request_id = frame_id;
            end
            PH_CHECK: begin
               csum_match = (b == payload_xor);
               phase      = PH_CR;
            end
            PH_CR: begin
               if (b != CR_BYTE) begin
                  phase          = PH_HUNT1;
                  emit           = 1'b1;
                  r.frame_status = ST_TRAILER;
               end else begin
                  phase = PH_LF;
               end
            end
            default: begin
               // LF position: trailer error wins over checksum
               phase = PH_HUNT1;
               emit  = 1'b1;
               if (b != LF_BYTE) r.frame_status = ST_TRAILER;
               else              r.frame_status = csum_match ? ST_OK : ST_CSUM;
            end
         endcase
         if (emit) begin
            expected_rsps.insert(expected_rsps.size(), r);
            if (r.frame_end) end_count[r.frame_status]++;
            else             payload_count++;
         end
      endfunction

      // Compare one accepted response with the oldest expectation
      function void check_rsp(logic [BYTE_W-1:0] ob, logic fe, logic [BYTE_W-1:0] rid,
                              logic [STATUS_W-1:0] st);
         parser_rsp_type e;
         if (expected_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response: byte %02h end %0b id %02h status %0d",
                        ob, fe, rid, st);
            return;
         end
         e = expected_rsps.pop_front();
         checked_count++;
         if (ob !== e.out_byte || fe !== e.frame_end || rid !== e.request_id ||
             st !== e.frame_status) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"response %0d mismatch: exp byte %02h end %0b id %02h ",
                         "status %0d, got byte %02h end %0b id %02h status %0d"},
                        checked_count, e.out_byte, e.frame_end, e.request_id,
                        e.frame_status, ob, fe, rid, st);
         end
      endfunction

      function int outstanding();
         return expected_rsps.size();
      endfunction
   endclass

   localparam int RANDOM_BYTES = 750;
   localparam int LONG_HOLD    = 80;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_frame_end;
   logic [BYTE_W-1:0]   rsp_request_id;
   logic [STATUS_W-1:0] rsp_frame_status;

   frame_scoreboard sb;
   int  burst_left = 0;
   int  bytes_sent = 0;
   int  frames_sent = 0;
   bit  long_hold_req = 1'b0;

   dollar_framed_packet_parser_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_request_id   (rsp_request_id),
      .rsp_frame_status (rsp_frame_status)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_rsp(rsp_out_byte, rsp_frame_end, rsp_request_id, rsp_frame_status);
   end

   // Offer one request byte, with burst gaps; called and returns at a falling edge
   task automatic push_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_rx_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] byte_other_than(logic [BYTE_W-1:0] x);
      logic [BYTE_W-1:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == x);
      return v;
   endfunction

   // One random stimulus unit: mostly well-formed frames, some noise and breakage
   task automatic send_random_unit();
      logic [BYTE_W-1:0] len, csum, pl;
      int kind, n;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         n = $urandom_range(1, 6);
         repeat (n) push_byte(8'($urandom_range(0, 255)));
      end else if (kind < 13) begin
         push_byte(SYNC_BYTE);
         push_byte(byte_other_than(SYNC_BYTE));
      end else if (kind < 18) begin
         push_byte(SYNC_BYTE);
         push_byte(SYNC_BYTE);
         push_byte(8'($urandom_range(0, 6)));
      end else begin
         n = $urandom_range(0, 99);
         if (n < 75)      len = 8'($urandom_range(7, 20));
         else if (n < 96) len = 8'($urandom_range(7, 40));
         else             len = 8'($urandom_range(7, 255));
         frames_sent++;
         push_byte(SYNC_BYTE);
         push_byte(SYNC_BYTE);
         push_byte(len);
         push_byte(8'($urandom_range(0, 255)));
         csum = '0;
         for (int i = 0; i < len - MIN_LENGTH; i++) begin
            pl   = 8'($urandom_range(0, 255));
            csum = csum ^ pl;
            push_byte(pl);
         end
         if ($urandom_range(0, 99) < 15) csum = csum ^ 8'($urandom_range(1, 255));
         push_byte(csum);
         if ($urandom_range(0, 99) < 5) begin
            push_byte(byte_other_than(CR_BYTE));
         end else begin
            push_byte(CR_BYTE);
            push_byte(($urandom_range(0, 99) < 5) ? byte_other_than(LF_BYTE) : LF_BYTE);
         end
      end
   endtask

   // Response side: stretches of different ready patterns, one long hold
   initial begin : rsp_side
      int  mode, stretch;
      bit  hold_done;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(8, 48);
         for (int k = 0; k < stretch; k++) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ((k % 4) != 3);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // Main sequence
   initial begin : req_side
      logic [BYTE_W-1:0] opener[$];
      sb = new();
      // lost second sync; zero length; empty payload; checksum miss; bad CR
      opener = '{SYNC_BYTE, 8'h41,
                 SYNC_BYTE, SYNC_BYTE, 8'h00,
                 SYNC_BYTE, SYNC_BYTE, 8'h07, 8'hff, 8'h00, CR_BYTE, LF_BYTE,
                 SYNC_BYTE, SYNC_BYTE, 8'h09, 8'ha5, 8'hff, 8'h00, 8'h55,
                 CR_BYTE, LF_BYTE,
                 SYNC_BYTE, SYNC_BYTE, 8'h07, 8'h12, 8'h00, LF_BYTE};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opener[i]) push_byte(opener[i]);

      while (bytes_sent < opener.size() + RANDOM_BYTES) begin
         if (bytes_sent > 200) long_hold_req = 1'b1;
         send_random_unit();
      end
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d request bytes in about %0d frames plus noise",
               bytes_sent, frames_sent);
      $display("checked %0d payload bytes; frame ends: ok %0d, checksum %0d, trailer %0d, short %0d",
               sb.payload_count, sb.end_count[ST_OK], sb.end_count[ST_CSUM],
               sb.end_count[ST_TRAILER], sb.end_count[ST_SHORT]);
      if (sb.fail_count == 0 && sb.outstanding() == 0)
         $display("dollar_framed_packet_parser_core verification clean");
      else
         $display("dollar_framed_packet_parser_core verification failed");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #2000000;
      $display("dollar_framed_packet_parser_core verification failed");
      $finish;
   end

endmodule
